// ----- hdl/tal_pkg.sv -----
// Shared types and codes for the Thumb ALU with condition flags.
package tal_pkg;

    typedef enum logic [4:0] {
        ACT_ADD     = 5'd0,
        ACT_SUB     = 5'd1,
        ACT_MOV_IMM = 5'd2,
        ACT_CMP     = 5'd3,
        ACT_LSL_IMM = 5'd4,
        ACT_LSR_IMM = 5'd5,
        ACT_ASR_IMM = 5'd6,
        ACT_AND     = 5'd7,
        ACT_EOR     = 5'd8,
        ACT_LSL_REG = 5'd9,
        ACT_LSR_REG = 5'd10,
        ACT_ASR_REG = 5'd11,
        ACT_ADC     = 5'd12,
        ACT_SBC     = 5'd13,
        ACT_ROR     = 5'd14,
        ACT_TST     = 5'd15,
        ACT_NEG     = 5'd16,
        ACT_CMN     = 5'd17,
        ACT_ORR     = 5'd18,
        ACT_MUL     = 5'd19,
        ACT_BIC     = 5'd20,
        ACT_MVN     = 5'd21,
        ACT_ADD_NF  = 5'd22,
        ACT_MOV_NF  = 5'd23
    } t_action;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift_kind;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        t_shift_kind kind;
        logic        imm;
    } t_shift_ctl;

    typedef struct packed {
        logic [31:0] value;
        logic        carry_upd;
        logic        carry;
    } t_shift_res;

    typedef struct packed {
        logic [31:0] value;
        logic        write_back;
        t_flags      flags;
    } t_result;

endpackage

// ----- hdl/tal_if.sv -----
// Handshake interfaces for the command and result words.
interface tal_cmd_if;
    logic        valid;
    logic        ready;
    logic [4:0]  action;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, output action, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input action, input operand_a, input operand_b,
                    output ready);
endinterface

interface tal_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic        write_back;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;

    modport source (output valid, output result_value, output write_back,
                    output flag_n, output flag_z, output flag_c, output flag_v,
                    input ready);
    modport sink   (input valid, input result_value, input write_back,
                    input flag_n, input flag_z, input flag_c, input flag_v,
                    output ready);
endinterface

// ----- hdl/tal_shift.sv -----
// Barrel shifter with ARM shift-amount rules and shifter carry out.
module tal_shift (
    input  tal_pkg::t_shift_ctl i_ctl,
    input  logic [31:0]         i_value,
    input  logic [7:0]          i_amount,
    output tal_pkg::t_shift_res o_res
);
    import tal_pkg::*;

    logic [7:0]  w_n;
    logic [4:0]  w_s;
    logic [32:0] w_left;
    logic [32:0] w_right;
    logic [31:0] w_asr;
    logic [63:0] w_rot;

    // immediate lsr/asr by zero encode a shift by 32
    always_comb begin
        w_n = i_amount;
        if (i_ctl.imm) begin
            w_n = {3'b000, i_amount[4:0]};
            if (i_amount[4:0] == 5'd0 && i_ctl.kind != SH_LSL) begin
                w_n = 8'd32;
            end
        end
    end

    assign w_s     = w_n[4:0];
    assign w_left  = {1'b0, i_value} << w_s;
    assign w_right = {i_value, 1'b0} >> w_s;
    assign w_asr   = $unsigned($signed(i_value) >>> w_s);
    assign w_rot   = {i_value, i_value} >> w_s;

    always_comb begin
        o_res.value     = i_value;
        o_res.carry_upd = 1'b0;
        o_res.carry     = 1'b0;
        if (w_n != 8'd0) begin
            o_res.carry_upd = 1'b1;
            case (i_ctl.kind)
                SH_LSL: begin
                    if (w_n < 8'd32) begin
                        o_res.value = w_left[31:0];
                        o_res.carry = w_left[32];
                    end else begin
                        o_res.value = 32'd0;
                        o_res.carry = (w_n == 8'd32) ? i_value[0] : 1'b0;
                    end
                end
                SH_LSR: begin
                    if (w_n < 8'd32) begin
                        o_res.value = w_right[32:1];
                        o_res.carry = w_right[0];
                    end else begin
                        o_res.value = 32'd0;
                        o_res.carry = (w_n == 8'd32) ? i_value[31] : 1'b0;
                    end
                end
                SH_ASR: begin
                    if (w_n < 8'd32) begin
                        o_res.value = w_asr;
                        o_res.carry = w_right[0];
                    end else begin
                        o_res.value = {32{i_value[31]}};
                        o_res.carry = i_value[31];
                    end
                end
                default: begin
                    if (w_s == 5'd0) begin
                        o_res.value = i_value;
                        o_res.carry = i_value[31];
                    end else begin
                        o_res.value = w_rot[31:0];
                        o_res.carry = w_right[0];
                    end
                end
            endcase
        end
    end

endmodule

// ----- hdl/tal_exec.sv -----
// Single-pass execute logic: adder, logic ops, multiplier, shifter and flags.
module tal_exec (
    input  logic [4:0]      i_action,
    input  logic [31:0]     i_operand_a,
    input  logic [31:0]     i_operand_b,
    input  tal_pkg::t_flags i_flags,
    output tal_pkg::t_result o_res
);
    import tal_pkg::*;

    logic [31:0] w_x;
    logic [31:0] w_y;
    logic        w_cin;
    logic [32:0] w_sum;
    logic        w_ovf;
    logic [31:0] w_prod;
    t_shift_ctl  w_sh_ctl;
    t_shift_res  w_sh_res;

    always_comb begin
        w_x   = i_operand_a;
        w_y   = i_operand_b;
        w_cin = 1'b0;
        case (i_action)
            ACT_SUB, ACT_CMP: begin
                w_y   = ~i_operand_b;
                w_cin = 1'b1;
            end
            ACT_ADC: begin
                w_cin = i_flags.c;
            end
            ACT_SBC: begin
                w_y   = ~i_operand_b;
                w_cin = i_flags.c;
            end
            ACT_NEG: begin
                w_x   = 32'd0;
                w_y   = ~i_operand_b;
                w_cin = 1'b1;
            end
            default: begin
                w_cin = 1'b0;
            end
        endcase
    end

    assign w_sum  = {1'b0, w_x} + {1'b0, w_y} + {32'd0, w_cin};
    assign w_ovf  = ~(w_x[31] ^ w_y[31]) & (w_x[31] ^ w_sum[31]);
    assign w_prod = i_operand_a * i_operand_b;

    always_comb begin
        w_sh_ctl.imm = 1'b0;
        case (i_action)
            ACT_LSL_IMM: begin
                w_sh_ctl.kind = SH_LSL;
                w_sh_ctl.imm  = 1'b1;
            end
            ACT_LSR_IMM: begin
                w_sh_ctl.kind = SH_LSR;
                w_sh_ctl.imm  = 1'b1;
            end
            ACT_ASR_IMM: begin
                w_sh_ctl.kind = SH_ASR;
                w_sh_ctl.imm  = 1'b1;
            end
            ACT_LSL_REG: w_sh_ctl.kind = SH_LSL;
            ACT_LSR_REG: w_sh_ctl.kind = SH_LSR;
            ACT_ASR_REG: w_sh_ctl.kind = SH_ASR;
            default:     w_sh_ctl.kind = SH_ROR;
        endcase
    end

    tal_shift u_shift (
        .i_ctl    (w_sh_ctl),
        .i_value  (i_operand_a),
        .i_amount (i_operand_b[7:0]),
        .o_res    (w_sh_res)
    );

    always_comb begin
        o_res.value      = 32'd0;
        o_res.write_back = 1'b1;
        o_res.flags      = i_flags;
        case (i_action)
            ACT_ADD, ACT_SUB, ACT_ADC, ACT_SBC, ACT_NEG: begin
                o_res.value   = w_sum[31:0];
                o_res.flags.c = w_sum[32];
                o_res.flags.v = w_ovf;
            end
            ACT_CMP, ACT_CMN: begin
                o_res.value      = w_sum[31:0];
                o_res.write_back = 1'b0;
                o_res.flags.c    = w_sum[32];
                o_res.flags.v    = w_ovf;
            end
            ACT_MOV_IMM: o_res.value = i_operand_b;
            ACT_LSL_IMM, ACT_LSR_IMM, ACT_ASR_IMM,
            ACT_LSL_REG, ACT_LSR_REG, ACT_ASR_REG, ACT_ROR: begin
                o_res.value = w_sh_res.value;
                if (w_sh_res.carry_upd) begin
                    o_res.flags.c = w_sh_res.carry;
                end
            end
            ACT_AND: o_res.value = i_operand_a & i_operand_b;
            ACT_EOR: o_res.value = i_operand_a ^ i_operand_b;
            ACT_TST: begin
                o_res.value      = i_operand_a & i_operand_b;
                o_res.write_back = 1'b0;
            end
            ACT_ORR: o_res.value = i_operand_a | i_operand_b;
            ACT_MUL: o_res.value = w_prod;
            ACT_BIC: o_res.value = i_operand_a & ~i_operand_b;
            ACT_MVN: o_res.value = ~i_operand_b;
            ACT_ADD_NF: o_res.value = i_operand_a + i_operand_b;
            ACT_MOV_NF: o_res.value = i_operand_b;
            default: begin
                o_res.value      = 32'd0;
                o_res.write_back = 1'b0;
            end
        endcase
        if (i_action <= ACT_MVN) begin
            o_res.flags.n = o_res.value[31];
            o_res.flags.z = (o_res.value == 32'd0);
        end
    end

endmodule

// ----- hdl/thumb_alu_with_flags.sv -----
// Top level of the Thumb ALU: command register, execute logic, result register, flags.
//
//  port    dir  handshake    payload
//  i_cmd   in   valid/ready  action, operand_a, operand_b
//  o_res   out  valid/ready  result_value, write_back, flag_n/z/c/v
//
// One word per cycle while o_res is ready; command register feeds result register.
// The path from the command register through adder or multiplier into the
// result register sets the cycle; flags update as a word enters the result
// register, so the next word sees them without a gap.
// Reset clears both valid bits and all flags.
// A stalled result holds both registers; the command side keeps accepting
// while either register has room.
module thumb_alu_with_flags (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tal_cmd_if.sink       i_cmd,
    tal_res_if.source     o_res
);
    import tal_pkg::*;

    logic        r_in_valid;
    logic [4:0]  r_action;
    logic [31:0] r_operand_a;
    logic [31:0] r_operand_b;
    logic        r_out_valid;
    t_result     r_out;
    t_flags      r_flags;
    t_result     n_out;
    logic        w_advance;

    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_advance;

    tal_exec u_exec (
        .i_action    (r_action),
        .i_operand_a (r_operand_a),
        .i_operand_b (r_operand_b),
        .i_flags     (r_flags),
        .o_res       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_out.flags;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_action    <= i_cmd.action;
            r_operand_a <= i_cmd.operand_a;
            r_operand_b <= i_cmd.operand_b;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out.value;
    assign o_res.write_back   = r_out.write_back;
    assign o_res.flag_n       = r_out.flags.n;
    assign o_res.flag_z       = r_out.flags.z;
    assign o_res.flag_c       = r_out.flags.c;
    assign o_res.flag_v       = r_out.flags.v;

`ifndef NO_ASSERTIONS
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_flags))
        else $error("flags changed without a word advancing");

    a_out_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.flags == r_flags))
        else $error("result word flags differ from kept flags");

    a_nf_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_action == ACT_ADD_NF || r_action == ACT_MOV_NF))
        |=> (r_flags == $past(r_flags)))
        else $error("flag-free operation changed the flags");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for the Thumb ALU: directed and random words under varied handshake idling.
`timescale 1ns / 100ps

module tb_top;
    import tal_pkg::*;

    localparam int          CLK_HALF       = 2;
    localparam int          RESET_CYCLES   = 5;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          LONG_HOLD      = 150;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          RANDOM_PER_PH  = 485;
    localparam logic [4:0]  ACT_FIRST_FREE = 5'd24;
    localparam logic [4:0]  ACT_LAST_FREE  = 5'd31;

    typedef struct packed {
        logic [4:0]  act;
        logic [31:0] a;
        logic [31:0] b;
    } t_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tal_cmd_if cmd_if ();
    tal_res_if res_if ();

    thumb_alu_with_flags i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_cmd    cmd_q[$];
    t_result alu_results_q[$];
    t_flags  alu_flags = '0;

    int n_queued;
    int n_accepted;
    int n_checked;
    int n_errors;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_requests;
    int holds_started;
    int hold_left;
    int idle_cycles;

    int tx_pct[4] = '{0, 47, 0, 24};
    int rx_pct[4] = '{0, 0, 47, 24};

    function automatic t_result thumb_execute(logic [4:0] act, logic [31:0] a, logic [31:0] b);
        t_result     res;
        t_flags      f;
        logic [32:0] sum;
        logic [31:0] r;
        logic [31:0] lhs;
        logic [31:0] addend;
        logic        cin;
        logic        arith;
        logic        upd_nz;
        int          n;
        f = alu_flags;
        r = '0;
        lhs = a;
        addend = b;
        cin = 1'b0;
        arith = 1'b0;
        upd_nz = 1'b1;
        res.write_back = 1'b1;
        case (act)
            ACT_ADD: arith = 1'b1;
            ACT_SUB: begin
                arith = 1'b1; addend = ~b; cin = 1'b1;
            end
            ACT_CMP: begin
                arith = 1'b1; addend = ~b; cin = 1'b1; res.write_back = 1'b0;
            end
            ACT_CMN: begin
                arith = 1'b1; res.write_back = 1'b0;
            end
            ACT_ADC: begin
                arith = 1'b1; cin = f.c;
            end
            ACT_SBC: begin
                arith = 1'b1; addend = ~b; cin = f.c;
            end
            ACT_NEG: begin
                arith = 1'b1; lhs = '0; addend = ~b; cin = 1'b1;
            end
            ACT_MOV_IMM: r = b;
            ACT_LSL_IMM: begin
                n = int'(b[4:0]);
                if (n == 0) begin
                    r = a;
                end else begin
                    f.c = a[32 - n];
                    r = a << n;
                end
            end
            ACT_LSR_IMM: begin
                n = int'(b[4:0]);
                if (n == 0) begin
                    f.c = a[31];
                    r = '0;
                end else begin
                    f.c = a[n - 1];
                    r = a >> n;
                end
            end
            ACT_ASR_IMM: begin
                n = int'(b[4:0]);
                if (n == 0) begin
                    f.c = a[31];
                    r = {32{a[31]}};
                end else begin
                    f.c = a[n - 1];
                    r = $signed(a) >>> n;
                end
            end
            ACT_LSL_REG: begin
                n = int'(b[7:0]);
                if (n == 0) begin
                    r = a;
                end else if (n < 32) begin
                    f.c = a[32 - n];
                    r = a << n;
                end else begin
                    f.c = (n == 32) ? a[0] : 1'b0;
                    r = '0;
                end
            end
            ACT_LSR_REG: begin
                n = int'(b[7:0]);
                if (n == 0) begin
                    r = a;
                end else if (n < 32) begin
                    f.c = a[n - 1];
                    r = a >> n;
                end else begin
                    f.c = (n == 32) ? a[31] : 1'b0;
                    r = '0;
                end
            end
            ACT_ASR_REG: begin
                n = int'(b[7:0]);
                if (n == 0) begin
                    r = a;
                end else if (n < 32) begin
                    f.c = a[n - 1];
                    r = $signed(a) >>> n;
                end else begin
                    f.c = a[31];
                    r = {32{a[31]}};
                end
            end
            ACT_ROR: begin
                n = int'(b[7:0]);
                if (n == 0) begin
                    r = a;
                end else if (b[4:0] == 5'd0) begin
                    f.c = a[31];
                    r = a;
                end else begin
                    n = int'(b[4:0]);
                    f.c = a[n - 1];
                    r = (a >> n) | (a << (32 - n));
                end
            end
            ACT_AND: r = a & b;
            ACT_EOR: r = a ^ b;
            ACT_ORR: r = a | b;
            ACT_BIC: r = a & ~b;
            ACT_MVN: r = ~b;
            ACT_MUL: r = a * b;
            ACT_TST: begin
                r = a & b;
                res.write_back = 1'b0;
            end
            ACT_ADD_NF: begin
                r = a + b;
                upd_nz = 1'b0;
            end
            ACT_MOV_NF: begin
                r = b;
                upd_nz = 1'b0;
            end
            default: begin
                r = '0;
                res.write_back = 1'b0;
                upd_nz = 1'b0;
            end
        endcase
        if (arith) begin
            sum = {1'b0, lhs} + {1'b0, addend} + {32'd0, cin};
            r = sum[31:0];
            f.c = sum[32];
            f.v = ~(lhs[31] ^ addend[31]) & (lhs[31] ^ r[31]);
        end
        if (upd_nz) begin
            f.n = r[31];
            f.z = (r == '0);
        end
        alu_flags = f;
        res.value = r;
        res.flags = f;
        return res;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_amount();
        logic [31:0] upper;
        upper = ($urandom_range(3) == 0) ? $urandom() : 32'h0;
        case ($urandom_range(3))
            0: return {upper[31:8], 8'($urandom_range(40))};
            1: return {upper[31:8], 8'($urandom_range(255))};
            2: return {upper[31:8], 8'(32 * $urandom_range(7))};
            default: return $urandom();
        endcase
    endfunction

    task automatic push_cmd(logic [4:0] act, logic [31:0] a, logic [31:0] b);
        cmd_q.push_back('{act: act, a: a, b: b});
        n_queued++;
    endtask

    task automatic push_random();
        logic [4:0] act;
        if ($urandom_range(99) < 4) begin
            act = 5'($urandom_range(ACT_LAST_FREE, ACT_FIRST_FREE));
        end else begin
            act = 5'($urandom_range(ACT_MOV_NF));
        end
        if (act inside {ACT_LSL_IMM, ACT_LSR_IMM, ACT_ASR_IMM, ACT_LSL_REG, ACT_LSR_REG,
                        ACT_ASR_REG, ACT_ROR}) begin
            push_cmd(act, pick_word(), pick_amount());
        end else begin
            push_cmd(act, pick_word(), pick_word());
        end
    endtask

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_cmd nxt;
        if (!i_rst_n) begin
            cmd_if.valid     <= 1'b0;
            cmd_if.action    <= ACT_ADD;
            cmd_if.operand_a <= '0;
            cmd_if.operand_b <= '0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                alu_results_q.push_back(thumb_execute(cmd_if.action, cmd_if.operand_a,
                                                      cmd_if.operand_b));
                n_accepted++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = cmd_q.pop_front();
                    cmd_if.valid     <= 1'b1;
                    cmd_if.action    <= nxt.act;
                    cmd_if.operand_a <= nxt.a;
                    cmd_if.operand_b <= nxt.b;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (alu_results_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, res_if.result_value);
                end else begin
                    want = alu_results_q.pop_front();
                    report("result_value", want.value, res_if.result_value);
                    report("write_back", 32'(want.write_back), 32'(res_if.write_back));
                    report("flag_n", 32'(want.flags.n), 32'(res_if.flag_n));
                    report("flag_z", 32'(want.flags.z), 32'(res_if.flag_z));
                    report("flag_c", 32'(want.flags.c), 32'(res_if.flag_c));
                    report("flag_v", 32'(want.flags.v), 32'(res_if.flag_v));
                end
                n_checked++;
            end
            if (holds_started != hold_requests) begin
                holds_started <= hold_requests;
                hold_left     <= LONG_HOLD;
                res_if.ready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_cmd(ACT_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        push_cmd(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0001);
        push_cmd(ACT_ADC, 32'h0000_0000, 32'h0000_0000);
        push_cmd(ACT_SUB, 32'h0000_0000, 32'h0000_0001);
        push_cmd(ACT_SBC, 32'h8000_0000, 32'h0000_0001);
        push_cmd(ACT_CMP, 32'h1234_5678, 32'h1234_5678);
        push_cmd(ACT_CMN, 32'h8000_0000, 32'h8000_0000);
        push_cmd(ACT_NEG, 32'h0000_0000, 32'h8000_0000);
        push_cmd(ACT_NEG, 32'hFFFF_FFFF, 32'h0000_0000);
        push_cmd(ACT_MOV_IMM, 32'hFFFF_FFFF, 32'h0000_00FF);
        push_cmd(ACT_LSL_IMM, 32'h8000_0001, 32'hFFFF_FFE0);
        push_cmd(ACT_LSR_IMM, 32'h8000_0000, 32'h0000_0000);
        push_cmd(ACT_ASR_IMM, 32'h8000_0000, 32'h0000_0000);
        push_cmd(ACT_LSL_REG, 32'h0000_0001, 32'h0000_0020);
        push_cmd(ACT_LSR_REG, 32'hFFFF_FFFF, 32'h0000_0021);
        push_cmd(ACT_ASR_REG, 32'h8000_0000, 32'h0000_00C8);
        push_cmd(ACT_ROR, 32'h8000_0001, 32'h0000_0020);
        push_cmd(ACT_ROR, 32'h0000_0001, 32'hFFFF_FF00);
        push_cmd(ACT_ROR, 32'h0000_0003, 32'h0000_0024);
        push_cmd(ACT_EOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(ACT_BIC, 32'hFFFF_FFFF, 32'h0000_FFFF);
        push_cmd(ACT_MVN, 32'h0000_0000, 32'h0000_0000);
        push_cmd(ACT_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(ACT_TST, 32'hAAAA_AAAA, 32'h5555_5555);
        push_cmd(ACT_ADD_NF, 32'hFFFF_FFFF, 32'h0000_0001);
        push_cmd(ACT_MOV_NF, 32'h0000_0000, 32'h8000_0000);
        push_cmd(ACT_LAST_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait (n_checked == n_queued);

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            if (ph == 0) begin
                hold_requests++;
            end
            repeat (RANDOM_PER_PH) push_random();
            wait (n_checked == n_queued);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (alu_results_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d results never arrived, expected 0 left, actual %0d",
                     $time, alu_results_q.size(), alu_results_q.size());
        end
        $display("Checked %0d of %0d ALU words over four idle and stall mixes,", n_checked,
                 n_accepted);
        $display("including a long output stall with the input held full; %0d mismatches.",
                 n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tal_pkg.sv
hdl/tal_if.sv
hdl/tal_shift.sv
hdl/tal_exec.sv
hdl/thumb_alu_with_flags.sv
dv/tb_top.sv
